### hw/rtl/uncompressed_png_stream_encoder_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the PNG stream encoder.
// Each macro expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef UNCOMPRESSED_PNG_STREAM_ENCODER_MACROS_SVH
`define UNCOMPRESSED_PNG_STREAM_ENCODER_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define UPNG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("upng assertion failed");
// Condition must never be seen outside reset.
`define UPNG_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("upng forbidden condition");
`else
`define UPNG_ASSERT(lbl, prop)
`define UPNG_ASSERT_NEVER(lbl, cond)
`endif

`endif

### hw/rtl/upng_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// upng_pkg
// Shared types, constants and helper functions of the PNG stream encoder.
// ---------------------------------------------------------------------------
package upng_pkg;

  localparam int unsigned MAX_DIMENSION = 4096;
  localparam int unsigned DIM_W         = 13;
  localparam int unsigned RAW_W         = 26;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [15:0] STORED_MAX = 16'hFFFF;

  // Configuration register indexes
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_MODE   = 3'd2;
  localparam logic [2:0] REG_FG     = 3'd3;
  localparam logic [2:0] REG_BG     = 3'd4;

  // One classified pixel handed from the front to the back
  typedef struct packed {
    logic                   trl_only;  // emit only the deferred trailer
    logic                   start;     // emit file header first
    logic                   filt;      // row starts: emit filter byte
    logic                   last_px;   // emit trailer after the pixel
    logic [23:0]            rgb;
    logic [DIM_W-1:0]       w;
    logic [DIM_W-1:0]       h;
    logic [RAW_W-1:0]       raw;       // raw byte count of the image
  } cmd_t;

  // Advance a reflected CRC-32 by one byte
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Big-endian byte k of a 32-bit word
  function automatic logic [7:0] be_byte(logic [31:0] v, logic [1:0] k);
    logic [7:0] r;
    unique case (k)
      2'd0: r = v[31:24];
      2'd1: r = v[23:16];
      2'd2: r = v[15:8];
      default: r = v[7:0];
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/upng_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// upng_front
// Holds the configuration, tracks raster position and classifies each
// pixel into a command for the byte sequencer.
// ---------------------------------------------------------------------------
module upng_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [23:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [15:0]          in_pixel_value,
  output upng_pkg::cmd_t       cmd,
  output logic                 cmd_push,
  input  logic                 cmd_full
);
  import upng_pkg::*;

  logic [DIM_W-1:0] width_r, height_r;
  logic             mode_r;
  logic [23:0]      fg_r, bg_r;

  logic             started_r, started_nxt;
  logic             trl_pend_r, trl_pend_nxt;
  logic [DIM_W-1:0] cur_w_r, cur_h_r;
  logic [11:0]      col_r, col_nxt;
  logic [11:0]      row_r, row_nxt;

  logic [DIM_W-1:0] w_clamp, h_clamp, cur_w, cur_h;
  logic [11:0]      col, row;
  logic             last_col, last_row, accept;
  logic [13:0]      w3p1;
  logic [23:0]      rgb;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end else begin
      r = d;
    end
    return r;
  endfunction

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(160);
      height_r <= DIM_W'(128);
      mode_r   <= 1'b0;
      fg_r     <= 24'hFFFFFF;
      bg_r     <= 24'h000000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        REG_MODE:   mode_r   <= cfg_data[0];
        REG_FG:     fg_r     <= cfg_data;
        REG_BG:     bg_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !cmd_full;
  assign accept   = in_valid && in_ready;
  assign cmd_push = accept;

  // Geometry: latch on the first pixel of an image
  assign w_clamp  = clamp_dim(width_r);
  assign h_clamp  = clamp_dim(height_r);
  assign cur_w    = started_r ? cur_w_r : w_clamp;
  assign cur_h    = started_r ? cur_h_r : h_clamp;
  assign col      = started_r ? col_r : 12'd0;
  assign row      = started_r ? row_r : 12'd0;
  assign last_col = ({1'b0, col} + 13'd1) == cur_w;
  assign last_row = ({1'b0, row} + 13'd1) == cur_h;
  assign w3p1     = {1'b0, cur_w} + {cur_w, 1'b0} + 14'd1;

  // Expand the pixel to 8-bit colour
  always_comb begin
    if (mode_r) begin
      rgb = in_pixel_value[0] ? fg_r : bg_r;
    end else begin
      rgb = {in_pixel_value[15:11], in_pixel_value[15:13],
             in_pixel_value[10:5],  in_pixel_value[10:9],
             in_pixel_value[4:0],   in_pixel_value[4:2]};
    end
  end

  // Build the command
  always_comb begin
    cmd.trl_only = trl_pend_r;
    cmd.start    = !trl_pend_r && !started_r;
    cmd.filt     = !trl_pend_r && (col == 12'd0);
    cmd.last_px  = !trl_pend_r && started_r && last_col && last_row;
    cmd.rgb      = rgb;
    cmd.w        = cur_w;
    cmd.h        = cur_h;
    cmd.raw      = RAW_W'(cur_h) * RAW_W'(w3p1);
  end

  // Advance raster position
  always_comb begin
    started_nxt  = started_r;
    trl_pend_nxt = trl_pend_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    if (accept) begin
      if (trl_pend_r) begin
        trl_pend_nxt = 1'b0;
        started_nxt  = 1'b0;
      end else begin
        started_nxt = 1'b1;
        col_nxt     = last_col ? 12'd0 : col + 12'd1;
        row_nxt     = last_col ? row + 12'd1 : row;
        if (last_col && last_row) begin
          col_nxt = 12'd0;
          row_nxt = 12'd0;
          if (!started_r) begin
            trl_pend_nxt = 1'b1;
          end else begin
            started_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r  <= 1'b0;
      trl_pend_r <= 1'b0;
      col_r      <= 12'd0;
      row_r      <= 12'd0;
    end else begin
      started_r  <= started_nxt;
      trl_pend_r <= trl_pend_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
    end
  end

  // Hold the geometry of the running image
  always_ff @(posedge clk) begin
    if (accept && !started_r) begin
      cur_w_r <= w_clamp;
      cur_h_r <= h_clamp;
    end
  end

endmodule

### hw/rtl/upng_cmdq.sv
`timescale 1ns / 1ps
`include "uncompressed_png_stream_encoder_macros.svh"
// ---------------------------------------------------------------------------
// upng_cmdq
// Two-entry command queue between the classifier and the byte sequencer.
// ---------------------------------------------------------------------------
module upng_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  upng_pkg::cmd_t push_cmd,
  input  logic           push,
  output logic           full,
  output upng_pkg::cmd_t head_cmd,
  output logic           head_valid,
  input  logic           pop
);
  import upng_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  `UPNG_ASSERT_NEVER(a_q_overflow, push && full && !pop)
  `UPNG_ASSERT_NEVER(a_q_underflow, pop && !head_valid)
  `UPNG_ASSERT_NEVER(a_q_count, count_r == 2'd3)

endmodule

### hw/rtl/upng_back.sv
`timescale 1ns / 1ps
`include "uncompressed_png_stream_encoder_macros.svh"
// ---------------------------------------------------------------------------
// upng_back
// Byte sequencer: emits header, stored-block framing, raw bytes, trailer
// one byte per cycle unless stalled, keeping CRC-32 and Adler-32 running.
// ---------------------------------------------------------------------------
module upng_back (
  input  logic           clk,
  input  logic           rst_n,
  input  upng_pkg::cmd_t cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_run_last,
  output logic           out_image_done
);
  import upng_pkg::*;

  localparam logic [1:0] PH_NEW = 2'd0;
  localparam logic [1:0] PH_HDR = 2'd1;
  localparam logic [1:0] PH_RAW = 2'd2;
  localparam logic [1:0] PH_TRL = 2'd3;

  logic [1:0]       ph_r, ph_nxt;
  logic [5:0]       idx_r, idx_nxt;
  logic [1:0]       slot_r, slot_nxt;
  logic [2:0]       bh_r, bh_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [15:0]      adl_lo_r, adl_lo_nxt, adl_hi_r, adl_hi_nxt;
  logic [RAW_W-1:0] raw_left_r, raw_left_nxt;
  logic [15:0]      blk_left_r, blk_left_nxt;
  logic [10:0]      blocks_r;
  logic [26:0]      len_r;

  logic             out_valid_r, out_last_r, out_done_r;
  logic [7:0]       out_byte_r;

  logic [1:0]       cur_ph, cur_slot;
  logic [5:0]       cur_idx;
  logic [2:0]       cur_bh;
  logic             in_bh, adv, out_take, done, is_data;
  logic             crc_it, crc_clr, last, img_done;
  logic [7:0]       byte_v;
  logic [15:0]      blk, nblk;
  logic [31:0]      crc_out, w32, h32, len32;
  logic [26:0]      q_x, q_sum;
  logic [12:0]      blocks5;
  logic [16:0]      lo_sum, hi_sum;
  logic [15:0]      lo_m;

  assign out_take = !out_valid_r || out_ready;
  assign adv      = cmd_valid && out_take;

  // Resolve the position for a fresh command
  always_comb begin
    if (ph_r == PH_NEW) begin
      cur_ph   = cmd.trl_only ? PH_TRL : (cmd.start ? PH_HDR : PH_RAW);
      cur_idx  = 6'd0;
      cur_slot = cmd.filt ? 2'd0 : 2'd1;
      cur_bh   = 3'd0;
    end else begin
      cur_ph   = ph_r;
      cur_idx  = idx_r;
      cur_slot = slot_r;
      cur_bh   = bh_r;
    end
  end

  assign in_bh   = (cur_bh != 3'd0) || (blk_left_r == 16'd0);
  assign blk     = (raw_left_r > RAW_W'(STORED_MAX)) ? STORED_MAX : raw_left_r[15:0];
  assign nblk    = ~blk;
  assign crc_out = ~crc_r;
  assign w32     = {{(32-DIM_W){1'b0}}, cmd.w};
  assign h32     = {{(32-DIM_W){1'b0}}, cmd.h};
  assign len32   = {5'd0, len_r};

  // Block count and IDAT length
  assign q_x     = {1'b0, cmd.raw} + 27'd65534;
  assign q_sum   = q_x + (q_x >> 16) + 27'd1;
  assign blocks5 = {blocks_r, 2'b00} + {2'b00, blocks_r};

  // Select the byte for the current position
  always_comb begin
    byte_v   = 8'h00;
    crc_it   = 1'b0;
    crc_clr  = 1'b0;
    is_data  = 1'b0;
    last     = 1'b0;
    img_done = 1'b0;
    done     = 1'b0;
    unique case (cur_ph)
      PH_HDR: begin
        priority if (cur_idx < 6'd8) begin
          unique case (cur_idx[2:0])
            3'd0: byte_v = 8'h89;
            3'd1: byte_v = 8'h50;
            3'd2: byte_v = 8'h4E;
            3'd3: byte_v = 8'h47;
            3'd4: byte_v = 8'h0D;
            3'd5: byte_v = 8'h0A;
            3'd6: byte_v = 8'h1A;
            default: byte_v = 8'h0A;
          endcase
        end else if (cur_idx < 6'd12) begin
          byte_v  = be_byte(32'd13, cur_idx[1:0]);
          crc_clr = (cur_idx == 6'd8);
        end else if (cur_idx < 6'd16) begin
          byte_v = be_byte(32'h49484452, cur_idx[1:0]);
          crc_it = 1'b1;
        end else if (cur_idx < 6'd20) begin
          byte_v = be_byte(w32, cur_idx[1:0]);
          crc_it = 1'b1;
        end else if (cur_idx < 6'd24) begin
          byte_v = be_byte(h32, cur_idx[1:0]);
          crc_it = 1'b1;
        end else if (cur_idx < 6'd29) begin
          byte_v = (cur_idx == 6'd24) ? 8'h08 : ((cur_idx == 6'd25) ? 8'h02 : 8'h00);
          crc_it = 1'b1;
        end else if (cur_idx < 6'd33) begin
          byte_v = be_byte(crc_out, 2'(cur_idx - 6'd29));
        end else if (cur_idx < 6'd37) begin
          byte_v  = be_byte(len32, 2'(cur_idx - 6'd33));
          crc_clr = (cur_idx == 6'd33);
        end else if (cur_idx < 6'd41) begin
          byte_v = be_byte(32'h49444154, 2'(cur_idx - 6'd37));
          crc_it = 1'b1;
        end else begin
          byte_v = (cur_idx == 6'd41) ? 8'h78 : 8'h01;
          crc_it = 1'b1;
        end
      end
      PH_RAW: begin
        crc_it = 1'b1;
        if (in_bh) begin
          unique case (cur_bh)
            3'd0: byte_v = {7'd0, raw_left_r <= RAW_W'(STORED_MAX)};
            3'd1: byte_v = blk[7:0];
            3'd2: byte_v = blk[15:8];
            3'd3: byte_v = nblk[7:0];
            default: byte_v = nblk[15:8];
          endcase
        end else begin
          is_data = 1'b1;
          unique case (cur_slot)
            2'd0: byte_v = 8'h00;
            2'd1: byte_v = cmd.rgb[23:16];
            2'd2: byte_v = cmd.rgb[15:8];
            default: byte_v = cmd.rgb[7:0];
          endcase
          last = (cur_slot == 2'd3) && !cmd.last_px;
          done = last;
        end
      end
      PH_TRL: begin
        priority if (cur_idx < 6'd4) begin
          byte_v = be_byte({adl_hi_r, adl_lo_r}, cur_idx[1:0]);
          crc_it = 1'b1;
        end else if (cur_idx < 6'd8) begin
          byte_v = be_byte(crc_out, cur_idx[1:0]);
        end else if (cur_idx < 6'd12) begin
          byte_v  = 8'h00;
          crc_clr = (cur_idx == 6'd8);
        end else if (cur_idx < 6'd16) begin
          byte_v = be_byte(32'h49454E44, cur_idx[1:0]);
          crc_it = 1'b1;
        end else begin
          byte_v = be_byte(crc_out, cur_idx[1:0]);
        end
        last     = (cur_idx == 6'd19);
        img_done = last;
        done     = last;
      end
      default: ;
    endcase
  end

  // Adler-32 step
  assign lo_sum = {1'b0, adl_lo_r} + {9'd0, byte_v};
  assign lo_m   = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
  assign hi_sum = {1'b0, adl_hi_r} + {1'b0, lo_m};

  // Advance the sequencer
  always_comb begin
    ph_nxt       = ph_r;
    idx_nxt      = idx_r;
    slot_nxt     = slot_r;
    bh_nxt       = bh_r;
    crc_nxt      = crc_r;
    adl_lo_nxt   = adl_lo_r;
    adl_hi_nxt   = adl_hi_r;
    raw_left_nxt = raw_left_r;
    blk_left_nxt = blk_left_r;
    if (adv) begin
      if (crc_clr) begin
        crc_nxt = CRC_INIT;
      end else if (crc_it) begin
        crc_nxt = crc_byte(crc_r, byte_v);
      end
      unique case (cur_ph)
        PH_HDR: begin
          if (cur_idx == 6'd0) begin
            raw_left_nxt = cmd.raw;
            blk_left_nxt = 16'd0;
            adl_lo_nxt   = 16'd1;
            adl_hi_nxt   = 16'd0;
          end
          if (cur_idx == 6'd42) begin
            ph_nxt   = PH_RAW;
            idx_nxt  = 6'd0;
            slot_nxt = cmd.filt ? 2'd0 : 2'd1;
            bh_nxt   = 3'd0;
          end else begin
            ph_nxt  = PH_HDR;
            idx_nxt = cur_idx + 6'd1;
          end
        end
        PH_RAW: begin
          ph_nxt   = PH_RAW;
          slot_nxt = cur_slot;
          idx_nxt  = cur_idx;
          if (in_bh) begin
            bh_nxt = (cur_bh == 3'd4) ? 3'd0 : cur_bh + 3'd1;
            if (cur_bh == 3'd4) begin
              blk_left_nxt = blk;
            end
          end else begin
            bh_nxt       = 3'd0;
            adl_lo_nxt   = lo_m;
            adl_hi_nxt   = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
            blk_left_nxt = blk_left_r - 16'd1;
            raw_left_nxt = raw_left_r - RAW_W'(1);
            if (cur_slot == 2'd3) begin
              ph_nxt  = cmd.last_px ? PH_TRL : PH_NEW;
              idx_nxt = 6'd0;
            end else begin
              slot_nxt = cur_slot + 2'd1;
            end
          end
        end
        PH_TRL: begin
          ph_nxt  = (cur_idx == 6'd19) ? PH_NEW : PH_TRL;
          idx_nxt = cur_idx + 6'd1;
        end
        default: ;
      endcase
    end
  end

  assign cmd_pop = adv && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r       <= PH_NEW;
      idx_r      <= 6'd0;
      slot_r     <= 2'd0;
      bh_r       <= 3'd0;
      crc_r      <= CRC_INIT;
      adl_lo_r   <= 16'd1;
      adl_hi_r   <= 16'd0;
      raw_left_r <= '0;
      blk_left_r <= 16'd0;
    end else begin
      ph_r       <= ph_nxt;
      idx_r      <= idx_nxt;
      slot_r     <= slot_nxt;
      bh_r       <= bh_nxt;
      crc_r      <= crc_nxt;
      adl_lo_r   <= adl_lo_nxt;
      adl_hi_r   <= adl_hi_nxt;
      raw_left_r <= raw_left_nxt;
      blk_left_r <= blk_left_nxt;
    end
  end

  // Hold block count and IDAT length while the signature goes out
  always_ff @(posedge clk) begin
    if (adv && cur_ph == PH_HDR && cur_idx == 6'd0) begin
      blocks_r <= q_sum[26:16];
    end
    if (adv && cur_ph == PH_HDR && cur_idx == 6'd1) begin
      len_r <= {1'b0, cmd.raw} + {14'd0, blocks5} + 27'd6;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= byte_v;
      out_last_r <= last;
      out_done_r <= img_done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_run_last   = out_last_r;
  assign out_image_done = out_done_r;

  `UPNG_ASSERT(a_done_last, out_valid_r && out_done_r |-> out_last_r)
  `UPNG_ASSERT_NEVER(a_bh_phase, bh_r != 3'd0 && ph_r != PH_RAW)
  `UPNG_ASSERT(a_trl_drained, ph_r == PH_TRL |-> raw_left_r == '0)
  `UPNG_ASSERT(a_data_used, adv && is_data |-> raw_left_r != '0 && blk_left_r != 16'd0)

endmodule

### hw/rtl/uncompressed_png_stream_encoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uncompressed_png_stream_encoder
// Streams raster pixels out as a complete truecolor PNG file.
//
//  Channel  | Ports                                       | Direction
//  ---------+---------------------------------------------+----------
//  pixels   | in_valid, in_ready, in_pixel_value           | in
//  bytes    | out_valid, out_ready, out_byte, out_run_last,| out
//           | out_image_done                              |
//  config   | cfg_we, cfg_index, cfg_data                 | in
//
// The byte sequencer sends one byte per cycle unless stalled; a pixel costs
// 3 bytes, 4 at the start of a row, plus 5 at each stored-block boundary, 43
// for the file header on the first pixel and 20 for the trailer on the last.
// A two-entry queue lets pixels be taken while earlier bytes still drain.
// Synchronous active-low reset; no clearing pass. out_ready low stalls the
// sequencer, and the queue then fills and drops in_ready.
// ---------------------------------------------------------------------------
module uncompressed_png_stream_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_pixel_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_image_done
);
  import upng_pkg::*;

  cmd_t front_cmd, head_cmd;
  logic push, full, head_valid, pop;

  upng_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_value (in_pixel_value),
    .cmd            (front_cmd),
    .cmd_push       (push),
    .cmd_full       (full)
  );

  upng_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cmd   (front_cmd),
    .push       (push),
    .full       (full),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .pop        (pop)
  );

  upng_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (head_cmd),
    .cmd_valid      (head_valid),
    .cmd_pop        (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_image_done (out_image_done)
  );

endmodule

### test/tb_uncompressed_png_stream_encoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_uncompressed_png_stream_encoder
// Self-checking bench for the PNG stream encoder. Whole images are streamed
// in under random sender and receiver idling. Each accepted pixel is run
// through a local encoder model that produces the expected file bytes, and
// every byte transfer is checked against the oldest expected byte. Geometry
// and colours change only between images, once the block has drained.
// ---------------------------------------------------------------------------
module tb_uncompressed_png_stream_encoder;
  import upng_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       done;
  } png_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_WIDTH;
  logic [23:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_pixel_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_run_last;
  logic        out_image_done;

  // Pixels waiting to be sent and file bytes waiting to come out
  logic [15:0] pixel_q[$];
  png_byte_t   file_q[$];
  png_byte_t   step_q[$];

  int unsigned errors = 0;
  int unsigned snd_idle_pct = 34;
  int unsigned rcv_idle_pct = 73;
  int unsigned rand_pixels = 0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int unsigned hold_left = 0;

  // Encoder model: register copies and image state
  logic [12:0] m_width, m_height;
  logic        m_mode;
  logic [23:0] m_fg, m_bg;
  logic [31:0] m_crc;
  int unsigned m_adler_lo, m_adler_hi;
  int unsigned m_col, m_row, m_blk_left, m_raw_left, m_w, m_h;
  bit          m_started, m_trailer_pending;

  uncompressed_png_stream_encoder DUT (.*);

  always #2 clk = ~clk;

  function automatic int unsigned clamp_dim(int unsigned d);
    if (d == 0) return 1;
    if (d > MAX_DIMENSION) return MAX_DIMENSION;
    return d;
  endfunction

  function automatic void put_byte(logic [7:0] v, bit crc_it);
    if (crc_it) begin
      m_crc = m_crc ^ {24'd0, v};
      for (int k = 0; k < 8; k++) begin
        m_crc = m_crc[0] ? ((m_crc >> 1) ^ 32'hEDB88320) : (m_crc >> 1);
      end
    end
    step_q.insert(step_q.size(), '{v, 1'b0, 1'b0});
  endfunction

  function automatic void put_word(logic [31:0] v, bit crc_it);
    put_byte(v[31:24], crc_it);
    put_byte(v[23:16], crc_it);
    put_byte(v[15:8], crc_it);
    put_byte(v[7:0], crc_it);
  endfunction

  // Append one raw image byte, opening a stored block where needed
  function automatic void put_raw(logic [7:0] v);
    int unsigned blk;
    logic [15:0] nblk;
    if (m_raw_left == 0) return;
    if (m_blk_left == 0) begin
      blk = (m_raw_left > 65535) ? 65535 : m_raw_left;
      nblk = ~blk[15:0];
      put_byte({7'd0, m_raw_left <= 65535}, 1'b1);
      put_byte(blk[7:0], 1'b1);
      put_byte(blk[15:8], 1'b1);
      put_byte(nblk[7:0], 1'b1);
      put_byte(nblk[15:8], 1'b1);
      m_blk_left = blk;
    end
    put_byte(v, 1'b1);
    m_adler_lo += v;
    if (m_adler_lo >= 65521) m_adler_lo -= 65521;
    m_adler_hi += m_adler_lo;
    if (m_adler_hi >= 65521) m_adler_hi -= 65521;
    m_blk_left--;
    m_raw_left--;
  endfunction

  function automatic void put_file_header();
    int unsigned raw, blocks;
    m_w = clamp_dim({19'd0, m_width});
    m_h = clamp_dim({19'd0, m_height});
    raw = m_h * (1 + 3 * m_w);
    blocks = (raw + 65534) / 65535;
    put_word(32'h89504E47, 1'b0);
    put_word(32'h0D0A1A0A, 1'b0);
    put_word(32'd13, 1'b0);
    m_crc = '1;
    put_word(32'h49484452, 1'b1);
    put_word(m_w, 1'b1);
    put_word(m_h, 1'b1);
    put_byte(8'd8, 1'b1);
    put_byte(8'd2, 1'b1);
    put_byte(8'd0, 1'b1);
    put_byte(8'd0, 1'b1);
    put_byte(8'd0, 1'b1);
    put_word(~m_crc, 1'b0);
    put_word(raw + 5 * blocks + 6, 1'b0);
    m_crc = '1;
    put_word(32'h49444154, 1'b1);
    put_byte(8'h78, 1'b1);
    put_byte(8'h01, 1'b1);
    m_raw_left = raw;
    m_blk_left = 0;
    m_adler_lo = 1;
    m_adler_hi = 0;
    m_col = 0;
    m_row = 0;
    m_started = 1'b1;
  endfunction

  // Adler-32, IDAT CRC and the IEND chunk
  function automatic void put_trailer();
    put_word({m_adler_hi[15:0], m_adler_lo[15:0]}, 1'b1);
    put_word(~m_crc, 1'b0);
    put_word(32'd0, 1'b0);
    m_crc = '1;
    put_word(32'h49454E44, 1'b1);
    put_word(~m_crc, 1'b0);
    step_q[step_q.size()-1].done = 1'b1;
    m_started = 1'b0;
    m_trailer_pending = 1'b0;
  endfunction

  // Work out the file bytes caused by one accepted pixel
  function automatic void encode_pixel(logic [15:0] px);
    logic [23:0] rgb;
    step_q.delete();
    if (m_trailer_pending) begin
      put_trailer();
    end else begin
      if (!m_started) put_file_header();
      if (m_mode) begin
        rgb = px[0] ? m_fg : m_bg;
      end else begin
        rgb = {px[15:11], px[15:13], px[10:5], px[10:9], px[4:0], px[4:2]};
      end
      if (m_col == 0) put_raw(8'd0);
      put_raw(rgb[23:16]);
      put_raw(rgb[15:8]);
      put_raw(rgb[7:0]);
      m_col++;
      if (m_col >= m_w) begin
        m_col = 0;
        m_row++;
      end
      if (m_row >= m_h) begin
        if (step_q.size() + 20 > 52) m_trailer_pending = 1'b1;
        else put_trailer();
      end
    end
    step_q[step_q.size()-1].run_last = 1'b1;
    foreach (step_q[i]) file_q.insert(file_q.size(), step_q[i]);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Sender: hold the pixel until its transfer, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_valid <= 1'b1;
        in_pixel_value <= pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Monitor: predict on pixel transfers, check byte transfers
  always @(posedge clk) begin
    png_byte_t exp_b;
    if (rst_n) begin
      if (in_valid && in_ready) encode_pixel(in_pixel_value);
      if (out_valid && out_ready) begin
        if (file_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h", out_byte));
        end else begin
          exp_b = file_q.pop_front();
          if (out_byte !== exp_b.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, exp_b.data));
          if (out_run_last !== exp_b.run_last)
            report_mismatch($sformatf("out_run_last %b, expected %b",
                                      out_run_last, exp_b.run_last));
          if (out_image_done !== exp_b.done)
            report_mismatch($sformatf("out_image_done %b, expected %b",
                                      out_image_done, exp_b.done));
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_WIDTH:  m_width = val[12:0];
      REG_HEIGHT: m_height = val[12:0];
      REG_MODE:   m_mode = val[0];
      REG_FG:     m_fg = val;
      REG_BG:     m_bg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every queued pixel is sent and every expected byte is out, then let it settle
  task automatic drain();
    @(posedge clk);
    while (pixel_q.size() != 0 || in_valid || file_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Configure and queue one whole image; pixels past the list are random
  task automatic queue_image(input int unsigned w, input int unsigned h, input bit mode,
                             input logic [23:0] fg, input logic [23:0] bg,
                             input logic [15:0] fixed[$]);
    int unsigned n;
    drain();
    write_reg(REG_WIDTH, 24'(w));
    write_reg(REG_HEIGHT, 24'(h));
    write_reg(REG_MODE, {23'd0, mode});
    write_reg(REG_FG, fg);
    write_reg(REG_BG, bg);
    n = clamp_dim(w) * clamp_dim(h);
    if (n == 1) n = 2;
    for (int i = 0; i < n; i++) begin
      pixel_q.insert(pixel_q.size(), i < fixed.size() ? fixed[i] : 16'($urandom()));
    end
  endtask

  task automatic random_images(input int unsigned target);
    logic [15:0] none[$];
    int unsigned w, h;
    while (rand_pixels < target) begin
      w = $urandom_range(8, 1);
      h = $urandom_range(5, 1);
      queue_image(w, h, 1'($urandom_range(1)), 24'($urandom()), 24'($urandom()), none);
      rand_pixels += (w * h == 1) ? 2 : w * h;
    end
  endtask

  initial begin
    m_width = 13'd160;
    m_height = 13'd128;
    m_mode = 1'b0;
    m_fg = 24'hFFFFFF;
    m_bg = 24'h000000;
    m_crc = '1;
    m_adler_lo = 1;
    m_adler_hi = 0;
    m_col = 0;
    m_row = 0;
    m_blk_left = 0;
    m_raw_left = 0;
    m_started = 1'b0;
    m_trailer_pending = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single pixel (deferred trailer), color extremes, mono, zero clamp
    queue_image(1, 1, 1'b0, 24'hFFFFFF, 24'h000000, '{16'h0000, 16'hFFFF});
    queue_image(3, 2, 1'b0, 24'h0, 24'h0,
                '{16'hFFFF, 16'h0000, 16'hF800, 16'h07E0, 16'h001F, 16'hAAAA});
    queue_image(2, 2, 1'b1, 24'hFFFFFF, 24'h000000,
                '{16'hFFFE, 16'h0001, 16'hFFFF, 16'h0000});
    queue_image(0, 0, 1'b1, 24'h000000, 24'hFFFFFF, '{16'h0001, 16'h0000});

    // Long receiver hold-off while the sender keeps offering
    drain();
    hold_req <= ~hold_req;
    random_images(60);

    snd_idle_pct = 73;
    rcv_idle_pct = 34;
    random_images(120);

    // No idling
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_images(185);

    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/upng_pkg.sv
hw/rtl/upng_front.sv
hw/rtl/upng_cmdq.sv
hw/rtl/upng_back.sv
hw/rtl/uncompressed_png_stream_encoder.sv
test/tb_uncompressed_png_stream_encoder.sv
